>>> rtl/core/outstanding_request_tracker_macros.svh
// Assertion helpers for the request tracker.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef OUTSTANDING_REQUEST_TRACKER_MACROS_SVH
`define OUTSTANDING_REQUEST_TRACKER_MACROS_SVH

// Same-cycle implication
`define ORT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ort_pkg.sv
package ort_pkg;

  localparam int ID_W        = 32;
  localparam int FREED_W     = 7;
  localparam int MAGIC_W     = ID_W + 1;          // reciprocal width for id / BUCKETS
  localparam int MUL_W       = (MAGIC_W + 1) / 2; // reciprocal bits per multiply step
  localparam int MOD_STEPS   = 3;                 // low half, high half, remainder
  localparam int MOD_CNT_W   = $clog2(MOD_STEPS);
  localparam logic [FREED_W-1:0] FREED_MAX = {FREED_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0]     family;
    logic [15:0]     subtype;
    logic [15:0]     flags;
    logic [ID_W-1:0] ctx;
  } payload_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] itime;
    payload_t        pay;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    request_id;
    payload_t           pay;
    logic [FREED_W-1:0] freed;
  } res_t;

endpackage

>>> rtl/core/ort_table.sv
module ort_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic [ADDR_W-1:0]   addr,
  input  logic                we,
  input  ort_pkg::entry_t     wdata,
  input  logic                re,
  output ort_pkg::entry_t     rdata
);

  ort_pkg::entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> rtl/core/ort_mod.sv
module ort_mod #(
  parameter int BUCKETS = 16,
  parameter int BKT_W   = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ort_pkg::ID_W-1:0] id,
  output logic                     done,
  output logic [BKT_W-1:0]         rem
);

  localparam int               SHIFT   = ort_pkg::ID_W + $clog2(BUCKETS);
  localparam int               MAGIC_W = ort_pkg::MAGIC_W;
  localparam int               MUL_W   = ort_pkg::MUL_W;
  localparam int               ACC_W   = ort_pkg::ID_W + MAGIC_W;
  localparam logic [63:0]      MAGIC   = ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) /
                                         64'(BUCKETS);
  localparam logic [MUL_W-1:0] MAG_LO  = MAGIC[MUL_W-1:0];
  localparam logic [MUL_W-1:0] MAG_HI  = MUL_W'(MAGIC[MAGIC_W-1:MUL_W]);

  logic [ort_pkg::ID_W-1:0]       val_r, val_nxt;
  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic [BKT_W-1:0]               rem_r, rem_nxt;
  logic [ort_pkg::MOD_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [MUL_W-1:0]               mul_b;
  logic [ort_pkg::ID_W+MUL_W-1:0] prod;
  logic [BKT_W-1:0]               quo;

  // one shared multiplier: low reciprocal half first, then the high half
  assign mul_b = (cnt_r == '0) ? MAG_LO : MAG_HI;
  assign prod  = val_r * mul_b;
  // only the low quotient bits matter for the remainder
  assign quo   = BKT_W'(acc_r >> SHIFT);

  // id mod BUCKETS by reciprocal multiply, then id - quotient * BUCKETS
  always_comb begin
    val_nxt  = val_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt = id;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '0) begin
        acc_nxt = ACC_W'(prod);
      end else if (cnt_r != ort_pkg::MOD_CNT_W'(ort_pkg::MOD_STEPS - 1)) begin
        acc_nxt = acc_r + (ACC_W'(prod) << MUL_W);
      end else begin
        rem_nxt  = val_r[BKT_W-1:0] - quo * BKT_W'(BUCKETS);
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    val_r <= val_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/ort_check.sv
module ort_check (
  input  ort_pkg::cmd_t            mode,
  input  ort_pkg::entry_t          entry,
  input  logic [ort_pkg::ID_W-1:0] key,
  input  logic [ort_pkg::ID_W-1:0] now,
  input  logic [ort_pkg::ID_W-1:0] max_age,
  output logic                     hit
);

  logic [ort_pkg::ID_W-1:0] age;

  // wrapped age of the entry
  assign age = now - entry.itime;

  // one compare per probed entry, chosen by the command
  always_comb begin
    case (mode)
      ort_pkg::CMD_INSERT: hit = !entry.valid;
      ort_pkg::CMD_REMOVE: hit = entry.valid && (entry.id == key);
      ort_pkg::CMD_SWEEP:  hit = entry.valid && (age > max_age);
      default:             hit = 1'b0;
    endcase
  end

endmodule

>>> rtl/core/outstanding_request_tracker.sv
// Insert / remove: the bucket remainder is computed, then one table read and one compare
//   per way, probing 1..WAYS ways and stopping on a hit or at the last way.
// Tick: no table probe. Sweep: one read and one compare per table entry. One word in
//   flight; the next is taken from the cycle after its result is registered (held on out_tready).
// Reset (rst_n low, synchronous) then a clearing pass over all BUCKETS*WAYS entries
//   with in_tready low; max_age resets to 60, next id to 1, time to 0.
`include "outstanding_request_tracker_macros.svh"

module outstanding_request_tracker #(
  parameter int BUCKETS = 16,
  parameter int WAYS    = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // configuration: max_age
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  // input: family, subtype, flags, context_word, lookup_id
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,
  // input: command
  input  logic [1:0]   in_tuser,
  // output: request_id, out_family, out_subtype, out_flags, out_context,
  //   freed_count, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,
  // output: status
  output logic [1:0]   out_tuser
);

  localparam int TBL    = BUCKETS * WAYS;
  localparam int ADDR_W = (TBL > 1) ? $clog2(TBL) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ID_W   = ort_pkg::ID_W;

  ort_pkg::state_t   state_r, state_nxt;
  ort_pkg::cmd_t     cmd_r, cmd_nxt, cmd_in;
  ort_pkg::payload_t pay_r, pay_nxt, pay_in;
  ort_pkg::res_t     res_r, res_nxt, out_r, out_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [ID_W-1:0]   now_r, now_nxt;
  logic [ID_W-1:0]   max_age_r;
  logic [ADDR_W-1:0] addr_r, addr_nxt, base;
  logic [WAY_W-1:0]  way_r, way_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_accept, out_free, last_way, last_tbl, hit;
  logic              mod_start, mod_done;
  logic [BKT_W-1:0]  mod_rem;
  logic              ram_we, ram_re;
  ort_pkg::entry_t   ram_wdata, ram_rdata, new_entry, freed_entry;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cmd_in    = ort_pkg::cmd_t'(in_tuser);
  assign pay_in    = '{family:  in_tdata[15:0],
                       subtype: in_tdata[31:16],
                       flags:   in_tdata[47:32],
                       ctx:     in_tdata[79:48]};
  assign last_way  = (way_r == WAY_W'(WAYS - 1));
  assign last_tbl  = (addr_r == ADDR_W'(TBL - 1));
  assign base      = ADDR_W'(mod_rem) * ADDR_W'(WAYS);

  assign new_entry = '{valid: 1'b1, id: key_r, itime: now_r, pay: pay_r};
  always_comb begin
    freed_entry       = ram_rdata;
    freed_entry.valid = 1'b0;
  end

  // bucket index of the key
  ort_mod #(.BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .id    (cmd_in == ort_pkg::CMD_INSERT ? next_id_r : in_tdata[111:80]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // entry store
  ort_table #(.DEPTH(TBL), .ADDR_W(ADDR_W)) u_table (
    .clk   (clk),
    .addr  (addr_r),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  // shared compare unit for every probe
  ort_check u_check (
    .mode    (cmd_r),
    .entry   (ram_rdata),
    .key     (key_r),
    .now     (now_r),
    .max_age (max_age_r),
    .hit     (hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ort_pkg::S_CLEAR: if (last_tbl) state_nxt = ort_pkg::S_IDLE;
      ort_pkg::S_IDLE: begin
        if (in_accept) begin
          case (cmd_in)
            ort_pkg::CMD_INSERT,
            ort_pkg::CMD_REMOVE: state_nxt = ort_pkg::S_MOD;
            ort_pkg::CMD_TICK:   state_nxt = ort_pkg::S_DONE;
            default:             state_nxt = ort_pkg::S_READ;
          endcase
        end
      end
      ort_pkg::S_MOD:  if (mod_done) state_nxt = ort_pkg::S_READ;
      ort_pkg::S_READ: state_nxt = ort_pkg::S_CHECK;
      ort_pkg::S_CHECK: begin
        if (cmd_r == ort_pkg::CMD_SWEEP) begin
          state_nxt = last_tbl ? ort_pkg::S_DONE : ort_pkg::S_READ;
        end else begin
          state_nxt = (hit || last_way) ? ort_pkg::S_DONE : ort_pkg::S_READ;
        end
      end
      ort_pkg::S_DONE: if (out_free) state_nxt = ort_pkg::S_IDLE;
      default:         state_nxt = ort_pkg::S_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    mod_start = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = freed_entry;
    case (state_r)
      ort_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ort_pkg::S_IDLE: begin
        in_tready = 1'b1;
        mod_start = in_tvalid &&
                    (cmd_in == ort_pkg::CMD_INSERT || cmd_in == ort_pkg::CMD_REMOVE);
      end
      ort_pkg::S_READ: ram_re = 1'b1;
      ort_pkg::S_CHECK: begin
        ram_we = hit;
        if (cmd_r == ort_pkg::CMD_INSERT) begin
          ram_wdata = new_entry;
        end
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cmd_nxt       = cmd_r;
    pay_nxt       = pay_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    key_nxt       = key_r;
    next_id_nxt   = next_id_r;
    now_nxt       = now_r;
    addr_nxt      = addr_r;
    way_nxt       = way_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ort_pkg::S_CLEAR: addr_nxt = addr_r + 1'b1;
      ort_pkg::S_IDLE: begin
        if (in_accept) begin
          cmd_nxt = cmd_in;
          pay_nxt = pay_in;
          res_nxt = '0;
          case (cmd_in)
            ort_pkg::CMD_INSERT: begin
              key_nxt     = next_id_r;
              next_id_nxt = next_id_r + 1'b1;
            end
            ort_pkg::CMD_REMOVE: key_nxt  = in_tdata[111:80];
            ort_pkg::CMD_TICK:   now_nxt  = now_r + 1'b1;
            default:             addr_nxt = '0;
          endcase
        end
      end
      ort_pkg::S_MOD: begin
        if (mod_done) begin
          addr_nxt = base;
          way_nxt  = '0;
        end
      end
      ort_pkg::S_CHECK: begin
        case (cmd_r)
          ort_pkg::CMD_INSERT: begin
            if (hit) begin
              res_nxt.request_id = key_r;
            end else if (last_way) begin
              res_nxt.status = ort_pkg::ST_FULL;
            end
          end
          ort_pkg::CMD_REMOVE: begin
            if (hit) begin
              res_nxt.request_id = key_r;
              res_nxt.pay        = ram_rdata.pay;
            end else if (last_way) begin
              res_nxt.status = ort_pkg::ST_MISS;
            end
          end
          ort_pkg::CMD_SWEEP: begin
            if (hit && res_r.freed != ort_pkg::FREED_MAX) begin
              res_nxt.freed = res_r.freed + 1'b1;
            end
          end
          default: ;
        endcase
        addr_nxt = addr_r + 1'b1;
        way_nxt  = way_r + 1'b1;
      end
      ort_pkg::S_DONE: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ort_pkg::S_CLEAR;
      addr_r      <= '0;
      next_id_r   <= ID_W'(1);
      now_r       <= '0;
      max_age_r   <= 32'd60;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      next_id_r   <= next_id_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_age_r <= cfg_wdata;
      end
    end
    cmd_r <= cmd_nxt;
    pay_r <= pay_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
    key_r <= key_nxt;
    way_r <= way_nxt;
  end

  // result word
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {1'b0, out_r.freed, out_r.pay.ctx, out_r.pay.flags,
                       out_r.pay.subtype, out_r.pay.family, out_r.request_id};

  `ORT_ASSERT_NOW(a_clear_blocks, state_r == ort_pkg::S_CLEAR, !in_tready, "word accepted during clear pass")
  `ORT_ASSERT_NEXT(a_one_word, in_tvalid && in_tready, !in_tready, "second word taken while busy")
  `ORT_ASSERT_NOW(a_mod_state, mod_done, state_r == ort_pkg::S_MOD, "remainder done outside lookup")
  `ORT_ASSERT_NOW(a_full_clean, out_tvalid && out_tuser == ort_pkg::ST_FULL, out_tdata == '0, "full result carries data")

endmodule
